[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the swipe detector rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define SWGD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define SWGD_ASSERT(lbl, prop, msg) \
  `SWGD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/swgd_pkg.sv]
// ----------------------------------------------------------------------------
// swgd_pkg
// types and constants shared by the swipe gesture detector modules
// ----------------------------------------------------------------------------
`default_nettype none

package swgd_pkg;

  localparam int COORD_W   = 12;
  localparam int ID_W      = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 2'd1;

  localparam logic [COORD_W-1:0] MIN_DISTANCE_RST = 12'd15;

  typedef enum logic [1:0] {
    ACT_DOWN   = 2'd0,
    ACT_UP     = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_CANCEL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // one touch table entry
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic               moved;
  } entry_t;

  // evaluation result for one event
  typedef struct packed {
    logic               hit;
    dir_e               dir;
    logic [COORD_W-1:0] dist_px;
  } result_t;

endpackage

`default_nettype wire

[design/swgd_table.sv]
// ----------------------------------------------------------------------------
// swgd_table
// per touch id start point and moved flag, updated by down, move and cancel
// ----------------------------------------------------------------------------
`default_nettype none

module swgd_table #(
  parameter int DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] idx_i,
  input  wire                            upd_en_i,
  input  swgd_pkg::action_e              action_i,
  input  wire [swgd_pkg::COORD_W-1:0]    pos_x_i,
  input  wire [swgd_pkg::COORD_W-1:0]    pos_y_i,
  output swgd_pkg::entry_t               entry_o
);

  swgd_pkg::entry_t tbl_q [DEPTH];

  assign entry_o = tbl_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (upd_en_i) begin
      case (action_i)
        swgd_pkg::ACT_DOWN: begin
          tbl_q[idx_i].start_x <= pos_x_i;
          tbl_q[idx_i].start_y <= pos_y_i;
          tbl_q[idx_i].moved   <= 1'b0;
        end
        swgd_pkg::ACT_MOVE:   tbl_q[idx_i].moved <= 1'b1;
        swgd_pkg::ACT_CANCEL: tbl_q[idx_i].moved <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/swgd_eval.sv]
// ----------------------------------------------------------------------------
// swgd_eval
// dominant axis, direction and threshold check for an up event
// ----------------------------------------------------------------------------
`default_nettype none

module swgd_eval (
  input  wire                           valid_i,
  input  wire                           in_range_i,
  input  swgd_pkg::action_e             action_i,
  input  wire [swgd_pkg::COORD_W-1:0]   pos_x_i,
  input  wire [swgd_pkg::COORD_W-1:0]   pos_y_i,
  input  swgd_pkg::entry_t              entry_i,
  input  wire [swgd_pkg::COORD_W-1:0]   min_distance_i,
  input  wire                           report_enable_i,
  output swgd_pkg::result_t             result_o
);

  logic                         x_ge, y_ge;
  logic [swgd_pkg::COORD_W-1:0] ax, ay;

  assign x_ge = pos_x_i >= entry_i.start_x;
  assign y_ge = pos_y_i >= entry_i.start_y;
  assign ax   = x_ge ? pos_x_i - entry_i.start_x : entry_i.start_x - pos_x_i;
  assign ay   = y_ge ? pos_y_i - entry_i.start_y : entry_i.start_y - pos_y_i;

  always_comb begin
    // ties go to the vertical axis
    if (ax > ay) begin
      result_o.dist_px = ax;
      result_o.dir  = (pos_x_i > entry_i.start_x) ? swgd_pkg::DIR_RIGHT : swgd_pkg::DIR_LEFT;
    end else begin
      result_o.dist_px = ay;
      result_o.dir  = (pos_y_i > entry_i.start_y) ? swgd_pkg::DIR_DOWN : swgd_pkg::DIR_UP;
    end
    result_o.hit = valid_i && in_range_i && (action_i == swgd_pkg::ACT_UP)
                   && entry_i.moved && report_enable_i
                   && (result_o.dist_px >= min_distance_i);
  end

endmodule

`default_nettype wire

[design/swipe_gesture_detector.sv]
// ----------------------------------------------------------------------------
// swipe_gesture_detector
// touch events in, swipe direction and distance out
//
//   channel  signals                                   direction
//   event    in_valid_i/in_ready_o, action/id/x/y      in
//   swipe    out_valid_o/out_ready_i, dir/dist         out
//   config   cfg_valid_i/cfg_ready_o, index/data       in
//
// one event per cycle unless stalled; an event goes from the input register
// through table lookup and compare into the swipe register when it is a swipe
// reset clears the touch table, min_distance to 15 and report_enable to 1
// the event side stalls only when the input register holds a swipe and the
// swipe register is full and not taken
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module swipe_gesture_detector #(
  parameter int NUM_TOUCH_IDS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [1:0]                        action_i,
  input  wire [swgd_pkg::ID_W-1:0]         touch_id_i,
  input  wire [swgd_pkg::COORD_W-1:0]      pos_x_i,
  input  wire [swgd_pkg::COORD_W-1:0]      pos_y_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [1:0]                       swipe_dir_o,
  output logic [swgd_pkg::COORD_W-1:0]     swipe_dist_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [swgd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [swgd_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  // only ids reachable through the id field get an entry
  localparam int ID_SPAN = 1 << swgd_pkg::ID_W;
  localparam int DEPTH   = (NUM_TOUCH_IDS < ID_SPAN) ? NUM_TOUCH_IDS : ID_SPAN;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [swgd_pkg::ID_W:0] ID_LIMIT = (swgd_pkg::ID_W + 1)'(DEPTH);

  logic [swgd_pkg::COORD_W-1:0] min_distance_q;
  logic                         report_enable_q;

  logic                         s1_valid_q, s1_valid_d;
  swgd_pkg::action_e            s1_action_q;
  logic [swgd_pkg::ID_W-1:0]    s1_id_q;
  logic [swgd_pkg::COORD_W-1:0] s1_x_q, s1_y_q;

  logic                         out_valid_q, out_valid_d;
  swgd_pkg::dir_e               swipe_dir_q;
  logic [swgd_pkg::COORD_W-1:0] swipe_dist_q;

  logic                         in_xfer, adv, in_range;
  swgd_pkg::entry_t             entry;
  swgd_pkg::result_t            res;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_distance_q  <= swgd_pkg::MIN_DISTANCE_RST;
      report_enable_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swgd_pkg::CFG_MIN_DISTANCE:  min_distance_q  <= cfg_data_i[swgd_pkg::COORD_W-1:0];
        swgd_pkg::CFG_REPORT_ENABLE: report_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  assign in_range   = {1'b0, s1_id_q} < ID_LIMIT;
  assign adv        = s1_valid_q && (!res.hit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_action_q <= swgd_pkg::action_e'(action_i);
      s1_id_q     <= touch_id_i;
      s1_x_q      <= pos_x_i;
      s1_y_q      <= pos_y_i;
    end
  end

  swgd_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (s1_id_q[IDX_W-1:0]),
    .upd_en_i (adv && in_range),
    .action_i (s1_action_q),
    .pos_x_i  (s1_x_q),
    .pos_y_i  (s1_y_q),
    .entry_o  (entry)
  );

  swgd_eval u_eval (
    .valid_i         (s1_valid_q),
    .in_range_i      (in_range),
    .action_i        (s1_action_q),
    .pos_x_i         (s1_x_q),
    .pos_y_i         (s1_y_q),
    .entry_i         (entry),
    .min_distance_i  (min_distance_q),
    .report_enable_i (report_enable_q),
    .result_o        (res)
  );

  // swipe register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && res.hit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.hit) begin
      swipe_dir_q  <= res.dir;
      swipe_dist_q <= res.dist_px;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign swipe_dir_o  = swipe_dir_q;
  assign swipe_dist_o = swipe_dist_q;

  `SWGD_ASSERT(a_hit_lands, (adv && res.hit) |=> out_valid_o, "swipe transfer lost")
  `SWGD_ASSERT(a_stall_full, !in_ready_o |-> (s1_valid_q && out_valid_q && res.hit), "stall without full pipe")
  `SWGD_ASSERT(a_hit_up_moved, res.hit |-> (s1_action_q == swgd_pkg::ACT_UP && entry.moved), "swipe from wrong event")

endmodule

`default_nettype wire
